@@ src/prem_pkg.sv @@
// Peak/RMS meter package: widths, register indexes, queue record, result
// and back-end state types. No dependencies.
package prem_pkg;

	localparam int COUNT_BITS    = 32;
	localparam int INDEX_BITS    = 16;
	localparam int SUM_BITS      = 64;
	localparam int SPB_BITS      = 32;
	localparam int LIMIT_BITS    = 16;
	localparam int CH_BITS       = 4;
	localparam int MAG_BITS      = 16;
	localparam int SQ_BITS       = 2 * MAG_BITS;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int DIV_STEPS     = SUM_BITS;
	localparam int FRAME_STEPS   = COUNT_BITS;
	localparam int SQRT_BITS     = 32;
	localparam int SQRT_STEPS    = SQRT_BITS / 2;
	localparam int STEP_BITS     = 6;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPB      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS = 2'd2;

	localparam logic [SPB_BITS-1:0]   SPB_RESET      = 32'd1;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = 16'd64;
	localparam logic [CH_BITS-1:0]    CHANNELS_RESET = 4'd2;

	localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
	localparam logic [SQRT_BITS-1:0]  SQRT_TOP  = 32'h4000_0000;

	localparam logic KIND_BUCKET  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [SPB_BITS-1:0]   spb;
		logic [LIMIT_BITS-1:0] limit;
		logic [CH_BITS-1:0]    ch;
	} cfg_t;

	// One queue record per sample that yields results: a bucket, a summary, or both.
	typedef struct packed {
		logic                  has_bkt;
		logic [15:0]           bkt_idx;
		logic [MAG_BITS-1:0]   bkt_peak;
		logic                  has_sum;
		logic [MAG_BITS-1:0]   gpeak;
		logic [SUM_BITS-1:0]   sum;
		logic [COUNT_BITS-1:0] cnt;
		logic                  ovf;
		logic [15:0]           sum_bidx;
		logic [CH_BITS-1:0]    ch;
	} rec_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] bucket_index;
		logic [15:0] peak_value;
		logic [15:0] rms_value;
		logic [31:0] frame_total;
		logic        malformed;
		logic        count_overflow;
		logic        last_result;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_BUCKET,
		BK_DIV,
		BK_SQRT,
		BK_SUMMARY
	} back_state_t;

endpackage

@@ src/peak_rms_envelope_meter_core.sv @@
// Channel      | Handshake               | Payload
// sample in    | push / full             | sample, last
// result out   | empty / pop             | kind, bucket_index, peak_value, rms_value,
//              |                         | frame_total, malformed, count_overflow, last_result
// config write | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Samples enter at one per cycle while full is low; the front registers each sample's
// magnitude and square, updates its accumulators once the record queue has room,
// and queues a record for each bucket or end of stream.
// A summary takes one queue read, 64 one-bit divide steps (frame divide alongside),
// 16 square-root steps and one output load, after the bucket load when its record also closes a bucket.
// full rises only while the four-entry record queue is full; arst_n clears all stream state.
// Top level of the meter; depends on prem_pkg, prem_fifo, prem_front, prem_back.
module peak_rms_envelope_meter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [15:0]                  sample,
	input  logic                                last,
	output logic                                empty,
	input  logic                                pop,
	output logic                                kind,
	output logic [15:0]                         bucket_index,
	output logic [15:0]                         peak_value,
	output logic [15:0]                         rms_value,
	output logic [31:0]                         frame_total,
	output logic                                malformed,
	output logic                                count_overflow,
	output logic                                last_result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prem_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [prem_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	prem_pkg::cfg_t    cfg_q;
	prem_pkg::rec_t    wr_rec;
	prem_pkg::rec_t    rd_rec;
	prem_pkg::result_t res;
	logic              q_wr;
	logic              q_full;
	logic              q_rd;
	logic              q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spb   <= prem_pkg::SPB_RESET;
			cfg_q.limit <= prem_pkg::LIMIT_RESET;
			cfg_q.ch    <= prem_pkg::CHANNELS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				prem_pkg::REG_SPB: begin
					cfg_q.spb <= cfg_data[prem_pkg::SPB_BITS-1:0];
				end
				prem_pkg::REG_LIMIT: begin
					cfg_q.limit <= cfg_data[prem_pkg::LIMIT_BITS-1:0];
				end
				prem_pkg::REG_CHANNELS: begin
					cfg_q.ch <= cfg_data[prem_pkg::CH_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	prem_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.sample (sample),
		.last   (last),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (wr_rec)
	);

	prem_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (wr_rec),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (rd_rec),
		.empty   (q_empty)
	);

	prem_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.q_data  (rd_rec),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign kind           = res.kind;
	assign bucket_index   = res.bucket_index;
	assign peak_value     = res.peak_value;
	assign rms_value      = res.rms_value;
	assign frame_total    = res.frame_total;
	assign malformed      = res.malformed;
	assign count_overflow = res.count_overflow;
	assign last_result    = res.last_result;

	a_queue_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("record written into a full queue");

	a_summary_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == prem_pkg::KIND_SUMMARY) |-> last_result)
		else $error("summary result without last_result");

	a_bucket_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == prem_pkg::KIND_BUCKET) |->
		(rms_value == 16'd0 && frame_total == 32'd0 && !malformed && !count_overflow))
		else $error("bucket result carries summary fields");

	a_rms_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == prem_pkg::KIND_SUMMARY) |->
		(peak_value <= 16'h8000 && rms_value <= peak_value))
		else $error("rms exceeds peak in summary");

endmodule

@@ src/prem_fifo.sv @@
// Short record queue between the front and back of the meter.
// Depends on prem_pkg (rec_t, FIFO_DEPTH, FIFO_PTR_BITS).
module prem_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  prem_pkg::rec_t wr_data,
	output logic           full,
	input  logic           rd,
	output prem_pkg::rec_t rd_data,
	output logic           empty
);

	prem_pkg::rec_t mem_q [prem_pkg::FIFO_DEPTH];
	logic [prem_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [prem_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [prem_pkg::FIFO_PTR_BITS:0]   count_q;
	logic do_wr;
	logic do_rd;

	assign full    = (count_q == (prem_pkg::FIFO_PTR_BITS + 1)'(prem_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ src/prem_front.sv @@
// Front of the meter: takes samples, keeps peak, square sum, count and
// bucket state, and queues a record for each bucket or end of stream.
// Depends on prem_pkg.
module prem_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [15:0]  sample,
	input  logic                last,
	input  prem_pkg::cfg_t      cfg,
	input  logic                q_full,
	output logic                q_wr,
	output prem_pkg::rec_t      q_data
);

	logic                              valid_s1;
	logic [prem_pkg::MAG_BITS-1:0]     mag_s1;
	logic [prem_pkg::SQ_BITS-1:0]      sq_s1;
	logic                              last_s1;

	logic [prem_pkg::MAG_BITS-1:0]     gpeak_q;
	logic [prem_pkg::SUM_BITS-1:0]     sum_q;
	logic [prem_pkg::COUNT_BITS-1:0]   cnt_q;
	logic [prem_pkg::SPB_BITS-1:0]     fill_q;
	logic [prem_pkg::INDEX_BITS-1:0]   bnum_q;
	logic [prem_pkg::MAG_BITS-1:0]     bmax_q;
	logic                              ovf_q;

	logic                              accept;
	logic                              advance;
	logic [15:0]                       raw;
	logic [prem_pkg::MAG_BITS-1:0]     mag_in;
	logic [prem_pkg::MAG_BITS-1:0]     gpeak_n;
	logic [prem_pkg::SUM_BITS-1:0]     sum_n;
	logic [prem_pkg::COUNT_BITS-1:0]   cnt_n;
	logic                              ovf_n;
	logic [prem_pkg::LIMIT_BITS-1:0]   idx_max_w;
	logic [prem_pkg::LIMIT_BITS-1:0]   limit_eff;
	logic                              in_env;
	logic [prem_pkg::SPB_BITS-1:0]     fill_inc;
	logic [prem_pkg::MAG_BITS-1:0]     bmax_n;
	logic                              bkt_done;
	logic [prem_pkg::INDEX_BITS-1:0]   bnum_inc;

	assign advance = valid_s1 && !q_full;
	assign full    = valid_s1 && q_full;
	assign accept  = push && !full;

	assign raw    = sample;
	assign mag_in = raw[15] ? (~raw + 16'd1) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1  <= mag_in;
			sq_s1   <= mag_in * mag_in;
			last_s1 <= last;
		end
	end

	always_comb begin
		gpeak_n = (mag_s1 > gpeak_q) ? mag_s1 : gpeak_q;

		// hold the count at its ceiling and flag it
		if (cnt_q == '1) begin
			cnt_n = cnt_q;
			sum_n = sum_q;
			ovf_n = 1'b1;
		end else begin
			cnt_n = cnt_q + 1'b1;
			sum_n = sum_q + prem_pkg::SUM_BITS'(sq_s1);
			ovf_n = ovf_q;
		end

		idx_max_w = prem_pkg::LIMIT_BITS'(prem_pkg::INDEX_MAX);
		limit_eff = (cfg.limit < idx_max_w) ? cfg.limit : idx_max_w;
		in_env    = (prem_pkg::LIMIT_BITS'(bnum_q) < limit_eff) && (cfg.spb != '0);
		fill_inc  = fill_q + 1'b1;
		bmax_n    = (mag_s1 > bmax_q) ? mag_s1 : bmax_q;
		bkt_done  = in_env && (fill_inc >= cfg.spb);
		bnum_inc  = bnum_q + 1'b1;

		q_data.has_bkt  = bkt_done;
		q_data.bkt_idx  = 16'(bnum_q);
		q_data.bkt_peak = bmax_n;
		q_data.has_sum  = last_s1;
		q_data.gpeak    = gpeak_n;
		q_data.sum      = sum_n;
		q_data.cnt      = cnt_n;
		q_data.ovf      = ovf_n;
		q_data.sum_bidx = bkt_done ? 16'(bnum_inc) : 16'(bnum_q);
		q_data.ch       = cfg.ch;

		q_wr = advance && (bkt_done || last_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpeak_q <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			fill_q  <= '0;
			bnum_q  <= '0;
			bmax_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				// end of stream: start the next one from scratch
				gpeak_q <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
				fill_q  <= '0;
				bnum_q  <= '0;
				bmax_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				gpeak_q <= gpeak_n;
				sum_q   <= sum_n;
				cnt_q   <= cnt_n;
				ovf_q   <= ovf_n;
				if (in_env) begin
					if (bkt_done) begin
						fill_q <= '0;
						bmax_q <= '0;
						bnum_q <= bnum_inc;
					end else begin
						fill_q <= fill_inc;
						bmax_q <= bmax_n;
					end
				end
			end
		end
	end

endmodule

@@ src/prem_back.sv @@
// Back of the meter: drains queue records, emits bucket results, and runs
// the mean-square divide, frame divide and square root for the summary.
// Depends on prem_pkg.
module prem_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              q_rd,
	input  prem_pkg::rec_t    q_data,
	input  logic              pop,
	output logic              empty,
	output prem_pkg::result_t res
);

	prem_pkg::back_state_t state_q;
	prem_pkg::back_state_t state_n;

	logic [prem_pkg::STEP_BITS-1:0]  step_q;
	prem_pkg::rec_t                  rec_q;
	logic [prem_pkg::CH_BITS-1:0]    ch_q;
	logic [prem_pkg::COUNT_BITS-1:0] rem_q;
	logic [prem_pkg::SUM_BITS-1:0]   quo_q;
	logic [prem_pkg::CH_BITS-1:0]    fr_rem_q;
	logic [prem_pkg::COUNT_BITS-1:0] fr_quo_q;
	logic [prem_pkg::SQRT_BITS-1:0]  v_q;
	logic [prem_pkg::SQRT_BITS-1:0]  root_q;
	logic [prem_pkg::SQRT_BITS-1:0]  bit_q;
	logic                            out_valid_q;
	prem_pkg::result_t               out_q;

	logic out_free;
	logic ld_bkt;
	logic ld_sum;
	logic div_last;
	logic sqrt_last;

	logic [prem_pkg::COUNT_BITS:0]   shift;
	logic                            ge;
	logic [prem_pkg::COUNT_BITS-1:0] rem_n;
	logic [prem_pkg::SUM_BITS-1:0]   quo_n;
	logic [prem_pkg::CH_BITS:0]      fr_shift;
	logic                            fr_ge;
	logic [prem_pkg::SQRT_BITS:0]    trial;
	logic                            take;

	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign res       = out_q;
	assign div_last  = (step_q == prem_pkg::STEP_BITS'(prem_pkg::DIV_STEPS - 1));
	assign sqrt_last = (step_q == prem_pkg::STEP_BITS'(prem_pkg::SQRT_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prem_pkg::BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		q_rd    = 1'b0;
		ld_bkt  = 1'b0;
		ld_sum  = 1'b0;
		case (state_q)
			prem_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_rd    = 1'b1;
					state_n = q_data.has_bkt ? prem_pkg::BK_BUCKET : prem_pkg::BK_DIV;
				end
			end
			prem_pkg::BK_BUCKET: begin
				if (out_free) begin
					ld_bkt  = 1'b1;
					state_n = rec_q.has_sum ? prem_pkg::BK_DIV : prem_pkg::BK_IDLE;
				end
			end
			prem_pkg::BK_DIV: begin
				if (div_last) begin
					state_n = prem_pkg::BK_SQRT;
				end
			end
			prem_pkg::BK_SQRT: begin
				if (sqrt_last) begin
					state_n = prem_pkg::BK_SUMMARY;
				end
			end
			prem_pkg::BK_SUMMARY: begin
				if (out_free) begin
					ld_sum  = 1'b1;
					state_n = prem_pkg::BK_IDLE;
				end
			end
			default: begin
				state_n = prem_pkg::BK_IDLE;
			end
		endcase
	end

	// restoring divide steps and digit-by-digit square root step
	always_comb begin
		shift    = {rem_q, quo_q[prem_pkg::SUM_BITS-1]};
		ge       = (shift >= {1'b0, rec_q.cnt});
		rem_n    = ge ? prem_pkg::COUNT_BITS'(shift - {1'b0, rec_q.cnt})
		              : shift[prem_pkg::COUNT_BITS-1:0];
		quo_n    = {quo_q[prem_pkg::SUM_BITS-2:0], ge};
		fr_shift = {fr_rem_q, fr_quo_q[prem_pkg::COUNT_BITS-1]};
		fr_ge    = (fr_shift >= {1'b0, ch_q});
		trial    = {1'b0, root_q} + {1'b0, bit_q};
		take     = ({1'b0, v_q} >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (q_rd || (state_q == prem_pkg::BK_DIV && div_last)) begin
			step_q <= '0;
		end else if (state_q == prem_pkg::BK_DIV || state_q == prem_pkg::BK_SQRT) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			rec_q    <= q_data;
			ch_q     <= (q_data.ch == '0) ? prem_pkg::CH_BITS'(1) : q_data.ch;
			rem_q    <= '0;
			quo_q    <= q_data.sum;
			fr_rem_q <= '0;
			fr_quo_q <= q_data.cnt;
		end else if (state_q == prem_pkg::BK_DIV) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			if (step_q < prem_pkg::STEP_BITS'(prem_pkg::FRAME_STEPS)) begin
				fr_rem_q <= fr_ge ? prem_pkg::CH_BITS'(fr_shift - {1'b0, ch_q})
				                  : fr_shift[prem_pkg::CH_BITS-1:0];
				fr_quo_q <= {fr_quo_q[prem_pkg::COUNT_BITS-2:0], fr_ge};
			end
			if (div_last) begin
				// mean square never exceeds 2^30, so the low word holds it
				v_q    <= quo_n[prem_pkg::SQRT_BITS-1:0];
				root_q <= '0;
				bit_q  <= prem_pkg::SQRT_TOP;
			end
		end else if (state_q == prem_pkg::BK_SQRT) begin
			if (take) begin
				v_q    <= prem_pkg::SQRT_BITS'({1'b0, v_q} - trial);
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_bkt || ld_sum) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_bkt) begin
			out_q.kind           <= prem_pkg::KIND_BUCKET;
			out_q.bucket_index   <= rec_q.bkt_idx;
			out_q.peak_value     <= rec_q.bkt_peak;
			out_q.rms_value      <= '0;
			out_q.frame_total    <= '0;
			out_q.malformed      <= 1'b0;
			out_q.count_overflow <= 1'b0;
			out_q.last_result    <= !rec_q.has_sum;
		end else if (ld_sum) begin
			out_q.kind           <= prem_pkg::KIND_SUMMARY;
			out_q.bucket_index   <= rec_q.sum_bidx;
			out_q.peak_value     <= rec_q.gpeak;
			out_q.rms_value      <= (rec_q.cnt == '0) ? 16'd0 : root_q[15:0];
			out_q.frame_total    <= 32'(fr_quo_q);
			out_q.malformed      <= (fr_rem_q != '0);
			out_q.count_overflow <= rec_q.ovf;
			out_q.last_result    <= 1'b1;
		end
	end

endmodule

@@ tb/peak_rms_envelope_meter_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for peak_rms_envelope_meter_core: a directed table, then random
// PCM streams under several register settings, scored against an in-bench predictor or a typed row.
// Depends on prem_pkg and the meter RTL.
module peak_rms_envelope_meter_core_tb;

	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 32;
	localparam int SETTLE_CYCLES = 100;
	localparam int PLAN_LEN      = 31;
	localparam logic [prem_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t                          op;
		logic [prem_pkg::CFG_IDX_BITS-1:0]  reg_idx;
		logic [prem_pkg::CFG_DATA_BITS-1:0] reg_data;
		logic [15:0]                        pcm;
		logic                               eos;
		logic                               typed;
		prem_pkg::result_t                  want;
	} plan_row_t;

	typedef struct packed {
		logic [prem_pkg::MAG_BITS-1:0]   peak;
		logic [prem_pkg::SUM_BITS-1:0]   sq_sum;
		logic [prem_pkg::COUNT_BITS-1:0] n_samples;
		logic [prem_pkg::SPB_BITS-1:0]   fill;
		logic [prem_pkg::INDEX_BITS-1:0] bucket_no;
		logic [prem_pkg::MAG_BITS-1:0]   bkt_max;
		logic                            saturated;
	} stream_state_t;

	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'h8000, 1'b0, 1'b1,
			'{prem_pkg::KIND_BUCKET, 16'd0, 16'h8000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'h7FFF, 1'b0, 1'b1,
			'{prem_pkg::KIND_BUCKET, 16'd1, 16'h7FFF, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
		// last sample also closes a bucket: bucket first, then summary
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd1, 1'b1, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_SPB, 32'd3, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_LIMIT, 32'd2, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_CHANNELS, 32'd3, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd100, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, -16'sd200, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd50, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd7, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd8, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, -16'sd9, 1'b0, 1'b0, '0},
		// bucket limit reached: these stay out of the envelope
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd5, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd5, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd5, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, -16'sd3, 1'b1, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_SPB, 32'd8, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_LIMIT, 32'd65535, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_CHANNELS, 32'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd1, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd2, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd3, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd4, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd5, 1'b0, 1'b0, '0},
		// shrink the bucket below the current fill: next sample closes it
		'{ROW_REG, prem_pkg::REG_SPB, 32'd2, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'd6, 1'b0, 1'b1,
			'{prem_pkg::KIND_BUCKET, 16'd0, 16'd6, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'h8000, 1'b1, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_SPB, 32'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_REG, prem_pkg::REG_CHANNELS, 32'd15, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, prem_pkg::REG_SPB, 32'd0, 16'h7FFF, 1'b1, 1'b1,
			'{prem_pkg::KIND_SUMMARY, 16'd0, 16'h7FFF, 16'h7FFF, 32'd0, 1'b1, 1'b0, 1'b1}}
	};

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               push = 1'b0;
	logic                               full;
	logic signed [15:0]                 sample = '0;
	logic                               last = 1'b0;
	logic                               empty;
	logic                               pop = 1'b0;
	logic                               kind;
	logic [15:0]                        bucket_index;
	logic [15:0]                        peak_value;
	logic [15:0]                        rms_value;
	logic [31:0]                        frame_total;
	logic                               malformed;
	logic                               count_overflow;
	logic                               last_result;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [prem_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [prem_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	prem_pkg::result_t expected_results[$];
	stream_state_t     meter = '0;
	prem_pkg::cfg_t    shadow_cfg = '{prem_pkg::SPB_RESET, prem_pkg::LIMIT_RESET,
		prem_pkg::CHANNELS_RESET};
	int                mismatch_count = 0;
	int                send_idle_pct = 38;
	int                recv_idle_pct = 72;

	peak_rms_envelope_meter_core dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 16; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= v)
				root = trial;
		end
		return root;
	endfunction

	// Advance the meter by one sample and queue the results it produces.
	task automatic predict_meter(input logic [15:0] pcm, input logic eos);
		logic [16:0]                   wide;
		logic [prem_pkg::MAG_BITS-1:0] mag;
		logic [31:0]                   ch_eff;
		prem_pkg::result_t             r;
		wide = pcm[15] ? 17'h10000 - {1'b0, pcm} : {1'b0, pcm};
		mag  = wide[15:0];
		if (mag > meter.peak)
			meter.peak = mag;
		if (meter.n_samples == '1) begin
			meter.saturated = 1'b1;
		end else begin
			meter.n_samples++;
			meter.sq_sum += 64'(mag) * 64'(mag);
		end
		if (meter.bucket_no < shadow_cfg.limit && shadow_cfg.spb != 0) begin
			if (mag > meter.bkt_max)
				meter.bkt_max = mag;
			meter.fill++;
			if (meter.fill >= shadow_cfg.spb) begin
				r              = '0;
				r.kind         = prem_pkg::KIND_BUCKET;
				r.bucket_index = meter.bucket_no;
				r.peak_value   = meter.bkt_max;
				r.last_result  = !eos;
				expected_results.insert(expected_results.size(), r);
				meter.bucket_no++;
				meter.fill    = '0;
				meter.bkt_max = '0;
			end
		end
		if (eos) begin
			ch_eff           = (shadow_cfg.ch == 0) ? 32'd1 : 32'(shadow_cfg.ch);
			r                = '0;
			r.kind           = prem_pkg::KIND_SUMMARY;
			r.bucket_index   = meter.bucket_no;
			r.peak_value     = meter.peak;
			if (meter.n_samples != 0)
				r.rms_value = 16'(floor_sqrt(meter.sq_sum / 64'(meter.n_samples)));
			r.frame_total    = meter.n_samples / ch_eff;
			r.malformed      = (meter.n_samples % ch_eff) != 0;
			r.count_overflow = meter.saturated;
			r.last_result    = 1'b1;
			expected_results.insert(expected_results.size(), r);
			meter = '0;
		end
	endtask

	task automatic send_sample(input logic [15:0] pcm, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		sample <= pcm;
		last   <= eos;
		do @(posedge clk); while (full);
		predict_meter(pcm, eos);
	endtask

	// Leave cfg_valid high; the caller drops it after the last write of a group.
	task automatic write_reg(input logic [prem_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [prem_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			prem_pkg::REG_SPB:      shadow_cfg.spb   = data;
			prem_pkg::REG_LIMIT:    shadow_cfg.limit = data[prem_pkg::LIMIT_BITS-1:0];
			prem_pkg::REG_CHANNELS: shadow_cfg.ch    = data[prem_pkg::CH_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(16) - 8);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic flag_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		mismatch_count++;
	endtask

	initial begin : result_checker
		prem_pkg::result_t got;
		prem_pkg::result_t want;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = {kind, bucket_index, peak_value, rms_value, frame_total,
					malformed, count_overflow, last_result};
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, kind %0d index %0d",
						$time, kind, bucket_index);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind)
						flag_mismatch("kind", want.kind, got.kind);
					if (got.bucket_index !== want.bucket_index)
						flag_mismatch("bucket_index", want.bucket_index, got.bucket_index);
					if (got.peak_value !== want.peak_value)
						flag_mismatch("peak_value", want.peak_value, got.peak_value);
					if (got.rms_value !== want.rms_value)
						flag_mismatch("rms_value", want.rms_value, got.rms_value);
					if (got.frame_total !== want.frame_total)
						flag_mismatch("frame_total", want.frame_total, got.frame_total);
					if (got.malformed !== want.malformed)
						flag_mismatch("malformed", want.malformed, got.malformed);
					if (got.count_overflow !== want.count_overflow)
						flag_mismatch("count_overflow", want.count_overflow, got.count_overflow);
					if (got.last_result !== want.last_result)
						flag_mismatch("last_result", want.last_result, got.last_result);
				end
			end
			pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [prem_pkg::SPB_BITS-1:0]   spb;
		logic [prem_pkg::LIMIT_BITS-1:0] lim;
		logic [prem_pkg::CH_BITS-1:0]    ch;
		int                              ch_eff;
		int                              sent;
		int                              len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].op == ROW_REG) begin
				if (i == 0 || PLAN[i-1].op != ROW_REG) begin
					wait_drained();
					repeat (SETTLE_CYCLES) @(posedge clk);
				end
				write_reg(PLAN[i].reg_idx, PLAN[i].reg_data);
				if (i == PLAN_LEN - 1 || PLAN[i+1].op != ROW_REG)
					cfg_valid <= 1'b0;
			end else begin
				send_sample(PLAN[i].pcm, PLAN[i].eos);
				// hand-written expectation takes the place of the predicted one
				if (PLAN[i].typed)
					expected_results[expected_results.size() - 1] = PLAN[i].want;
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase / 4)
				0: begin send_idle_pct = 38; recv_idle_pct = 72; end
				1: begin send_idle_pct = 72; recv_idle_pct = 38; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (phase % 6)
				0: begin
					spb = $urandom_range(5, 1);
					lim = 16'($urandom_range(16, 1));
					ch  = 4'($urandom_range(8, 1));
				end
				1: begin spb = 1; lim = 1; ch = 1; end
				2: begin spb = '1; lim = '1; ch = 8; end
				3: begin spb = '0; lim = '0; ch = '0; end
				4: begin spb = $urandom(); lim = 16'($urandom()); ch = 4'($urandom()); end
				default: begin spb = $urandom_range(3, 1); lim = '1; ch = 4'd15; end
			endcase
			// a stream left open by the previous phase carries over the new settings
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_reg(prem_pkg::REG_SPB, spb);
			write_reg(prem_pkg::REG_LIMIT, prem_pkg::CFG_DATA_BITS'(lim));
			write_reg(prem_pkg::REG_CHANNELS, prem_pkg::CFG_DATA_BITS'(ch));
			if (phase % 6 == 1)
				write_reg(REG_UNUSED, $urandom());
			cfg_valid <= 1'b0;

			ch_eff = (ch == 0) ? 1 : int'(ch);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(3) == 0)
					len = $urandom_range(20, 1);
				else
					len = ch_eff * $urandom_range(6, 1);
				for (int k = 0; k < len && sent < PHASE_ITEMS; k++) begin
					if ($urandom_range(39) == 0)
						wait_drained();
					send_sample(pick_sample(), k == len - 1);
					sent++;
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
